/* rtl/aac_program_config_element_parser_core_macros.svh */
// Assertion macros shared by the program config element parser RTL.
`ifndef AAC_PROGRAM_CONFIG_ELEMENT_PARSER_CORE_MACROS_SVH
`define AAC_PROGRAM_CONFIG_ELEMENT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AACPCE_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define AACPCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/aacpce_pkg.sv */
// Types, position codes and field widths of the program config element parser.
package aacpce_pkg;

    // Parse positions; the code of each field position is also its output field id.
    typedef enum logic [4:0] {
        POS_TAG            = 5'd0,
        POS_OBJ_TYPE       = 5'd1,
        POS_SF_INDEX       = 5'd2,
        POS_NUM_FRONT      = 5'd3,
        POS_NUM_SIDE       = 5'd4,
        POS_NUM_BACK       = 5'd5,
        POS_NUM_LFE        = 5'd6,
        POS_NUM_ASSOC      = 5'd7,
        POS_NUM_CC         = 5'd8,
        POS_MONO_PRESENT   = 5'd9,
        POS_MONO_NUM       = 5'd10,
        POS_STEREO_PRESENT = 5'd11,
        POS_STEREO_NUM     = 5'd12,
        POS_MATRIX_PRESENT = 5'd13,
        POS_MATRIX_IDX     = 5'd14,
        POS_SURROUND       = 5'd15,
        POS_FRONT_CPE      = 5'd16,
        POS_FRONT_TAG      = 5'd17,
        POS_SIDE_CPE       = 5'd18,
        POS_SIDE_TAG       = 5'd19,
        POS_BACK_CPE       = 5'd20,
        POS_BACK_TAG       = 5'd21,
        POS_LFE_TAG        = 5'd22,
        POS_ASSOC_TAG      = 5'd23,
        POS_CC_IND_SW      = 5'd24,
        POS_CC_TAG         = 5'd25,
        POS_COMMENT_BYTES  = 5'd26,
        POS_COMMENT_DATA   = 5'd27,
        POS_PAD            = 5'd28
    } t_pos;

    typedef struct packed {
        logic [4:0] field_id;
        logic [7:0] field_value;
        logic [7:0] element_index;
        logic       last_of_element;
    } t_result;

    // Number of bits in the syntax field at a position; the padding position has none.
    function automatic logic [3:0] field_width(input t_pos pos);
        logic [3:0] w;
        case (pos)
            POS_OBJ_TYPE, POS_NUM_LFE, POS_MATRIX_IDX:         w = 4'd2;
            POS_NUM_ASSOC:                                     w = 4'd3;
            POS_MONO_PRESENT, POS_STEREO_PRESENT, POS_MATRIX_PRESENT,
            POS_SURROUND, POS_FRONT_CPE, POS_SIDE_CPE, POS_BACK_CPE,
            POS_CC_IND_SW:                                     w = 4'd1;
            POS_COMMENT_BYTES, POS_COMMENT_DATA:               w = 4'd8;
            POS_PAD:                                           w = 4'd0;
            default:                                           w = 4'd4;
        endcase
        return w;
    endfunction

endpackage

/* rtl/aac_program_config_element_parser_core.sv */
// Top level of the AAC program config element parser: input register, parser, result register.
//
// Input channel: one bitstream bit per item on i_bit_in, MSB of each field first,
// accepted when i_valid is high and o_stall is low.
// Output channel: one item per completed syntax field (field id, value, list index,
// end-of-element flag), taken when o_valid is high and i_stall is low.
// A bit is captured in the input register when it is accepted and is parsed once the
// result register is free to take a result; its result, if any, is registered in the
// result register, which drives o_valid, and the item is taken when i_stall is low.
// Throughput is one bit per cycle while the receiver does not stall; the parse state
// update is a single pass of small logic behind the input register.
// Padding bits before the comment byte count produce no items.
// When the receiver stalls, the waiting result holds and the parser stops; the
// input register can still take one more bit before o_stall rises.
// Reset (synchronous, active low) empties both registers and places the parser at
// the element instance tag with a bit phase of zero. A write on i_cfg_we sets the
// start bit phase and restarts the parser; write only while the block is idle.
`include "aac_program_config_element_parser_core_macros.svh"

module aac_program_config_element_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_start_bit_phase,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_bit_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [4:0] o_field_id,
    output logic [7:0] o_field_value,
    output logic [7:0] o_element_index,
    output logic       o_last_of_element
);
    import aacpce_pkg::*;

    logic    r_in_valid;
    logic    r_in_bit;
    logic    r_out_valid;
    t_result r_out;
    logic    w_out_free;
    logic    w_step;
    logic    w_has_result;
    t_result w_result;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_step;

    aacpce_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_phase  (i_cfg_start_bit_phase),
        .i_step       (w_step),
        .i_bit        (r_in_bit),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_bit <= i_bit_in;
        end
        if (w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_field_id        = r_out.field_id;
    assign o_field_value     = r_out.field_value;
    assign o_element_index   = r_out.element_index;
    assign o_last_of_element = r_out.last_of_element;

    `AACPCE_ASSERT(a_stall_needs_item, i_clk, i_rst_n, o_stall, r_in_valid && r_out_valid && i_stall)
    `AACPCE_ASSERT(a_result_only_on_step, i_clk, i_rst_n, w_has_result, w_step)
    `AACPCE_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, w_has_result, o_valid && (r_out == $past(w_result)))

endmodule

/* rtl/aacpce_parse.sv */
// Parse state machine: field assembly, list counts, padding and result forming.
`include "aac_program_config_element_parser_core_macros.svh"

module aacpce_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_phase,
    input  logic                 i_step,
    input  logic                 i_bit,
    output logic                 o_has_result,
    output aacpce_pkg::t_result  o_result
);
    import aacpce_pkg::*;

    t_pos       r_pos, n_pos;
    logic [3:0] r_bits, n_bits;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_idx, n_idx;
    logic [3:0] r_front, n_front;
    logic [3:0] r_side, n_side;
    logic [3:0] r_back, n_back;
    logic [1:0] r_lfe, n_lfe;
    logic [2:0] r_assoc, n_assoc;
    logic [3:0] r_cc, n_cc;
    logic [7:0] r_comment, n_comment;
    logic [2:0] r_phase, n_phase;

    t_pos       w_pos;
    logic [2:0] w_phase_inc;
    logic [3:0] w_bits_inc;
    logic [7:0] w_shift_in;
    logic       w_done;
    logic [5:0] w_nonempty;
    logic       w_in_list;

    // A position code outside the syntax is taken as the element start.
    assign w_pos       = (r_pos > POS_PAD) ? POS_TAG : r_pos;
    assign w_phase_inc = r_phase + 3'd1;
    assign w_bits_inc  = r_bits + 4'd1;
    assign w_shift_in  = {r_shift[6:0], i_bit};
    assign w_done      = (w_bits_inc >= field_width(w_pos));
    assign w_nonempty  = {r_cc != 4'd0, r_assoc != 3'd0, r_lfe != 2'd0,
                          r_back != 4'd0, r_side != 4'd0, r_front != 4'd0};
    assign w_in_list   = ((w_pos >= POS_FRONT_CPE) && (w_pos <= POS_CC_TAG))
                         || (w_pos == POS_COMMENT_DATA);

    // First non-empty list at or after group g, else padding or the comment count.
    function automatic t_pos list_from(input logic [2:0] g, input logic [5:0] ne,
                                       input logic phase_zero);
        t_pos p;
        if (g <= 3'd0 && ne[0])      p = POS_FRONT_CPE;
        else if (g <= 3'd1 && ne[1]) p = POS_SIDE_CPE;
        else if (g <= 3'd2 && ne[2]) p = POS_BACK_CPE;
        else if (g <= 3'd3 && ne[3]) p = POS_LFE_TAG;
        else if (g <= 3'd4 && ne[4]) p = POS_ASSOC_TAG;
        else if (g <= 3'd5 && ne[5]) p = POS_CC_IND_SW;
        else if (phase_zero)         p = POS_COMMENT_BYTES;
        else                         p = POS_PAD;
        return p;
    endfunction

    function automatic logic more_entries(input logic [7:0] idx, input logic [7:0] cnt);
        return ({1'b0, idx} + 9'd1) < {1'b0, cnt};
    endfunction

    // Next state.
    always_comb begin
        logic phase_zero;
        phase_zero = (w_phase_inc == 3'd0);
        n_pos     = w_pos;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_idx     = r_idx;
        n_front   = r_front;
        n_side    = r_side;
        n_back    = r_back;
        n_lfe     = r_lfe;
        n_assoc   = r_assoc;
        n_cc      = r_cc;
        n_comment = r_comment;
        n_phase   = r_phase;
        if (i_cfg_we) begin
            n_pos     = POS_TAG;
            n_bits    = 4'd0;
            n_shift   = 8'd0;
            n_idx     = 8'd0;
            n_front   = 4'd0;
            n_side    = 4'd0;
            n_back    = 4'd0;
            n_lfe     = 2'd0;
            n_assoc   = 3'd0;
            n_cc      = 4'd0;
            n_comment = 8'd0;
            n_phase   = i_cfg_phase;
        end else if (i_step) begin
            n_phase = w_phase_inc;
            if (w_pos == POS_PAD) begin
                n_pos = phase_zero ? POS_COMMENT_BYTES : POS_PAD;
            end else if (!w_done) begin
                n_shift = w_shift_in;
                n_bits  = w_bits_inc;
            end else begin
                n_shift = 8'd0;
                n_bits  = 4'd0;
                case (w_pos)
                    POS_NUM_FRONT: begin
                        n_front = w_shift_in[3:0];
                        n_pos   = POS_NUM_SIDE;
                    end
                    POS_NUM_SIDE: begin
                        n_side = w_shift_in[3:0];
                        n_pos  = POS_NUM_BACK;
                    end
                    POS_NUM_BACK: begin
                        n_back = w_shift_in[3:0];
                        n_pos  = POS_NUM_LFE;
                    end
                    POS_NUM_LFE: begin
                        n_lfe = w_shift_in[1:0];
                        n_pos = POS_NUM_ASSOC;
                    end
                    POS_NUM_ASSOC: begin
                        n_assoc = w_shift_in[2:0];
                        n_pos   = POS_NUM_CC;
                    end
                    POS_NUM_CC: begin
                        n_cc  = w_shift_in[3:0];
                        n_pos = POS_MONO_PRESENT;
                    end
                    POS_MONO_PRESENT: begin
                        n_pos = w_shift_in[0] ? POS_MONO_NUM : POS_STEREO_PRESENT;
                    end
                    POS_STEREO_PRESENT: begin
                        n_pos = w_shift_in[0] ? POS_STEREO_NUM : POS_MATRIX_PRESENT;
                    end
                    POS_MATRIX_PRESENT: begin
                        if (w_shift_in[0]) begin
                            n_pos = POS_MATRIX_IDX;
                        end else begin
                            n_idx = 8'd0;
                            n_pos = list_from(3'd0, w_nonempty, phase_zero);
                        end
                    end
                    POS_SURROUND: begin
                        n_idx = 8'd0;
                        n_pos = list_from(3'd0, w_nonempty, phase_zero);
                    end
                    POS_FRONT_CPE: n_pos = POS_FRONT_TAG;
                    POS_SIDE_CPE:  n_pos = POS_SIDE_TAG;
                    POS_BACK_CPE:  n_pos = POS_BACK_TAG;
                    POS_CC_IND_SW: n_pos = POS_CC_TAG;
                    POS_FRONT_TAG: begin
                        if (more_entries(r_idx, {4'd0, r_front})) begin
                            n_idx = r_idx + 8'd1;
                            n_pos = POS_FRONT_CPE;
                        end else begin
                            n_idx = 8'd0;
                            n_pos = list_from(3'd1, w_nonempty, phase_zero);
                        end
                    end
                    POS_SIDE_TAG: begin
                        if (more_entries(r_idx, {4'd0, r_side})) begin
                            n_idx = r_idx + 8'd1;
                            n_pos = POS_SIDE_CPE;
                        end else begin
                            n_idx = 8'd0;
                            n_pos = list_from(3'd2, w_nonempty, phase_zero);
                        end
                    end
                    POS_BACK_TAG: begin
                        if (more_entries(r_idx, {4'd0, r_back})) begin
                            n_idx = r_idx + 8'd1;
                            n_pos = POS_BACK_CPE;
                        end else begin
                            n_idx = 8'd0;
                            n_pos = list_from(3'd3, w_nonempty, phase_zero);
                        end
                    end
                    POS_LFE_TAG: begin
                        if (more_entries(r_idx, {6'd0, r_lfe})) begin
                            n_idx = r_idx + 8'd1;
                            n_pos = POS_LFE_TAG;
                        end else begin
                            n_idx = 8'd0;
                            n_pos = list_from(3'd4, w_nonempty, phase_zero);
                        end
                    end
                    POS_ASSOC_TAG: begin
                        if (more_entries(r_idx, {5'd0, r_assoc})) begin
                            n_idx = r_idx + 8'd1;
                            n_pos = POS_ASSOC_TAG;
                        end else begin
                            n_idx = 8'd0;
                            n_pos = list_from(3'd5, w_nonempty, phase_zero);
                        end
                    end
                    POS_CC_TAG: begin
                        if (more_entries(r_idx, {4'd0, r_cc})) begin
                            n_idx = r_idx + 8'd1;
                            n_pos = POS_CC_IND_SW;
                        end else begin
                            n_idx = 8'd0;
                            n_pos = list_from(3'd6, w_nonempty, phase_zero);
                        end
                    end
                    POS_COMMENT_BYTES: begin
                        n_comment = w_shift_in;
                        n_idx     = 8'd0;
                        n_pos     = (w_shift_in != 8'd0) ? POS_COMMENT_DATA : POS_TAG;
                    end
                    POS_COMMENT_DATA: begin
                        if (more_entries(r_idx, r_comment)) begin
                            n_idx = r_idx + 8'd1;
                            n_pos = POS_COMMENT_DATA;
                        end else begin
                            n_idx = 8'd0;
                            n_pos = POS_TAG;
                        end
                    end
                    default: n_pos = t_pos'(w_pos + 5'd1);
                endcase
            end
        end
    end

    // Result of the current bit.
    always_comb begin
        o_has_result             = i_step && !i_cfg_we && (w_pos != POS_PAD) && w_done;
        o_result.field_id        = 5'(w_pos);
        o_result.field_value     = w_shift_in;
        o_result.element_index   = w_in_list ? r_idx : 8'd0;
        o_result.last_of_element =
            ((w_pos == POS_COMMENT_BYTES) && (w_shift_in == 8'd0))
            || ((w_pos == POS_COMMENT_DATA) && !more_entries(r_idx, r_comment));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_TAG;
            r_bits    <= 4'd0;
            r_shift   <= 8'd0;
            r_idx     <= 8'd0;
            r_front   <= 4'd0;
            r_side    <= 4'd0;
            r_back    <= 4'd0;
            r_lfe     <= 2'd0;
            r_assoc   <= 3'd0;
            r_cc      <= 4'd0;
            r_comment <= 8'd0;
            r_phase   <= 3'd0;
        end else begin
            r_pos     <= n_pos;
            r_bits    <= n_bits;
            r_shift   <= n_shift;
            r_idx     <= n_idx;
            r_front   <= n_front;
            r_side    <= n_side;
            r_back    <= n_back;
            r_lfe     <= n_lfe;
            r_assoc   <= n_assoc;
            r_cc      <= n_cc;
            r_comment <= n_comment;
            r_phase   <= n_phase;
        end
    end

    `AACPCE_ASSERT(a_pad_is_silent, i_clk, i_rst_n, i_step && (w_pos == POS_PAD), !o_has_result)
    `AACPCE_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, o_has_result && o_result.last_of_element, r_pos == POS_TAG)
    `AACPCE_ASSERT(a_index_only_in_lists, i_clk, i_rst_n, r_idx != 8'd0, w_in_list)
    `AACPCE_ASSERT(a_field_bits_bounded, i_clk, i_rst_n, r_bits != 4'd0, r_bits < field_width(w_pos))

endmodule
